// ===== src/purifier_fan_ion_sensor_tick_core_assert.svh =====
// assertion macros for the purifier fan / ion / sensor tick core
// expects i_clk and i_rst_n in the including module
`ifndef PURIFIER_FAN_ION_SENSOR_TICK_CORE_ASSERT_SVH
`define PURIFIER_FAN_ION_SENSOR_TICK_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PFIST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PFIST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pfist_pkg.sv =====
// shared types and codes for the purifier fan / ion / sensor tick core
// no dependencies
`default_nettype none

package pfist_pkg;

    // work mode codes
    localparam logic [2:0] WORK_AUTO  = 3'd0;
    localparam logic [2:0] WORK_LOW   = 3'd1;
    localparam logic [2:0] WORK_MID   = 3'd2;
    localparam logic [2:0] WORK_HIGH  = 3'd3;
    localparam logic [2:0] WORK_SLEEP = 3'd4;

    // fan level codes
    localparam logic [2:0] LVL_OFF   = 3'd0;
    localparam logic [2:0] LVL_SLEEP = 3'd1;
    localparam logic [2:0] LVL_LOW   = 3'd2;
    localparam logic [2:0] LVL_MID   = 3'd3;
    localparam logic [2:0] LVL_HIGH  = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_RPM_SLEEP    = 3'd0;
    localparam logic [2:0] REG_RPM_LOW      = 3'd1;
    localparam logic [2:0] REG_RPM_MID      = 3'd2;
    localparam logic [2:0] REG_RPM_HIGH     = 3'd3;
    localparam logic [2:0] REG_STARTUP_HOLD = 3'd4;
    localparam logic [2:0] REG_SENSOR_DELAY = 3'd5;
    localparam logic [2:0] REG_BOOT_WINDOW  = 3'd6;

    localparam logic [15:0] ON_TIME_MAX = 16'hffff;

    typedef struct packed {
        logic [15:0] rpm_sleep;
        logic [15:0] rpm_low;
        logic [15:0] rpm_mid;
        logic [15:0] rpm_high;
        logic [7:0]  startup_hold_ticks;
        logic [15:0] sensor_off_delay;
        logic [7:0]  boot_sensor_window;
    } t_cfg;

    typedef struct packed {
        logic       power_on;
        logic       fan_fault;
        logic       tilt_fault;
        logic       door_left_open;
        logic       door_right_open;
        logic       link_fault;
        logic [2:0] work_mode;
        logic       ion_allowed;
        logic [1:0] pm_level;
        logic [1:0] voc_level;
        logic [1:0] formaldehyde_level;
        logic [7:0] run_time;
    } t_item;

    typedef struct packed {
        logic [7:0]  hold_count;
        logic [15:0] off_delay_count;
        logic [15:0] on_time_count;
        logic [1:0]  last_quality;
        logic [2:0]  last_auto_level;
    } t_state;

    typedef struct packed {
        logic [2:0]  fan_level;
        logic [15:0] target_rpm;
        logic        ion_on;
        logic        sensor_supply_on;
        logic [15:0] sensor_on_time;
        logic [1:0]  worst_quality;
        logic [2:0]  auto_fan_level;
    } t_result;

endpackage

`default_nettype wire

// ===== src/purifier_fan_ion_sensor_tick_core.sv =====
// Purifier control tick core. Each input transfer is one 100 ms tick and yields
// exactly one result transfer. The tick logic is combinational and runs
// between the input port and the result register, and a new tick is accepted
// in every cycle in which the result register is empty or being emptied, so
// the sustained rate is one tick per clock. Configuration writes are always
// accepted and take effect for the next tick; write them only while idle.
// depends on pfist_pkg, pfist_tick_calc and the assertion macro header
`default_nettype none

`include "purifier_fan_ion_sensor_tick_core_assert.svh"

module purifier_fan_ion_sensor_tick_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // tick input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [0] power_on, [1] fan_fault, [2] tilt_fault, [3] door_left_open,
    // [4] door_right_open, [5] link_fault, [8:6] work_mode, [9] ion_allowed,
    // [11:10] pm_level, [13:12] voc_level, [15:14] formaldehyde_level,
    // [23:16] run_time
    input  wire logic [23:0] s_axis_tdata,
    // result output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [2:0] fan_level, [18:3] target_rpm, [19] ion_on, [20] sensor_supply_on,
    // [36:21] sensor_on_time, [38:37] worst_quality, [41:39] auto_fan_level,
    // [47:42] zero
    output logic [47:0]      m_axis_tdata,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    pfist_pkg::t_cfg    r_cfg;
    pfist_pkg::t_state  r_state;
    pfist_pkg::t_state  n_state;
    pfist_pkg::t_item   item;
    pfist_pkg::t_result result;
    pfist_pkg::t_result r_out;
    logic               r_out_valid;
    logic               in_xfer;

    assign item.power_on           = s_axis_tdata[0];
    assign item.fan_fault          = s_axis_tdata[1];
    assign item.tilt_fault         = s_axis_tdata[2];
    assign item.door_left_open     = s_axis_tdata[3];
    assign item.door_right_open    = s_axis_tdata[4];
    assign item.link_fault         = s_axis_tdata[5];
    assign item.work_mode          = s_axis_tdata[8:6];
    assign item.ion_allowed        = s_axis_tdata[9];
    assign item.pm_level           = s_axis_tdata[11:10];
    assign item.voc_level          = s_axis_tdata[13:12];
    assign item.formaldehyde_level = s_axis_tdata[15:14];
    assign item.run_time           = s_axis_tdata[23:16];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    pfist_tick_calc u_calc (
        .i_item   (item),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rpm_sleep          <= 16'd300;
            r_cfg.rpm_low            <= 16'd500;
            r_cfg.rpm_mid            <= 16'd650;
            r_cfg.rpm_high           <= 16'd800;
            r_cfg.startup_hold_ticks <= 8'd30;
            r_cfg.sensor_off_delay   <= 16'd600;
            r_cfg.boot_sensor_window <= 8'd60;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pfist_pkg::REG_RPM_SLEEP:    r_cfg.rpm_sleep          <= i_cfg_data;
                pfist_pkg::REG_RPM_LOW:      r_cfg.rpm_low            <= i_cfg_data;
                pfist_pkg::REG_RPM_MID:      r_cfg.rpm_mid            <= i_cfg_data;
                pfist_pkg::REG_RPM_HIGH:     r_cfg.rpm_high           <= i_cfg_data;
                pfist_pkg::REG_STARTUP_HOLD: r_cfg.startup_hold_ticks <= i_cfg_data[7:0];
                pfist_pkg::REG_SENSOR_DELAY: r_cfg.sensor_off_delay   <= i_cfg_data;
                pfist_pkg::REG_BOOT_WINDOW:  r_cfg.boot_sensor_window <= i_cfg_data[7:0];
                default: begin
                    // writes past the last register are dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_state <= n_state;
            end
            if (in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.auto_fan_level, r_out.worst_quality,
                            r_out.sensor_on_time, r_out.sensor_supply_on, r_out.ion_on,
                            r_out.target_rpm, r_out.fan_level};

    `PFIST_ASSERT_NOW(a_off_no_rpm, r_out_valid && (r_out.fan_level == pfist_pkg::LVL_OFF),
        r_out.target_rpm == 16'd0, "fan off but nonzero target rpm")
    `PFIST_ASSERT_NOW(a_no_supply_no_time, r_out_valid && !r_out.sensor_supply_on,
        r_out.sensor_on_time == 16'd0, "sensor supply off with on-time left")
    `PFIST_ASSERT_NOW(a_empty_takes, !r_out_valid, s_axis_tready,
        "result register empty but input stalled")
    `PFIST_ASSERT_NEXT(a_power_reloads, in_xfer && item.power_on,
        r_state.off_delay_count == $past(r_cfg.sensor_off_delay),
        "off delay not reloaded while powered")

endmodule

`default_nettype wire

// ===== src/pfist_tick_calc.sv =====
// per-tick decision logic: fan level, rpm, ion, sensor supply and counters
// depends on pfist_pkg
`default_nettype none

module pfist_tick_calc (
    input  pfist_pkg::t_item   i_item,
    input  pfist_pkg::t_state  i_state,
    input  pfist_pkg::t_cfg    i_cfg,
    output pfist_pkg::t_state  o_state,
    output pfist_pkg::t_result o_result
);

    logic        enabled;
    logic [1:0]  worst;
    logic [2:0]  lvl;
    logic        sense;
    logic [15:0] rpm;
    logic [15:0] on_time_mid;

    assign enabled = i_item.power_on && !i_item.fan_fault && !i_item.tilt_fault
                     && !i_item.door_left_open && !i_item.door_right_open
                     && !i_item.link_fault;

    always_comb begin
        worst = i_item.pm_level;
        if (i_item.voc_level > worst) begin
            worst = i_item.voc_level;
        end
        if (i_item.formaldehyde_level > worst) begin
            worst = i_item.formaldehyde_level;
        end
    end

    always_comb begin
        o_state     = i_state;
        lvl         = pfist_pkg::LVL_OFF;
        on_time_mid = i_state.on_time_count;

        if (enabled) begin
            if (i_state.hold_count != 8'd0) begin
                o_state.hold_count = i_state.hold_count - 8'd1;
                lvl = pfist_pkg::LVL_MID;
            end else begin
                case (i_item.work_mode)
                    pfist_pkg::WORK_AUTO: begin
                        lvl = {1'b0, worst} + 3'd1;
                        o_state.last_quality    = worst;
                        o_state.last_auto_level = {1'b0, worst} + 3'd1;
                    end
                    pfist_pkg::WORK_LOW:  lvl = pfist_pkg::LVL_LOW;
                    pfist_pkg::WORK_MID:  lvl = pfist_pkg::LVL_MID;
                    pfist_pkg::WORK_HIGH: lvl = pfist_pkg::LVL_HIGH;
                    // sleep and the unused codes
                    default:              lvl = pfist_pkg::LVL_SLEEP;
                endcase
            end
        end else begin
            o_state.hold_count = i_cfg.startup_hold_ticks;
        end

        // sensor supply keeps running for a while after power-off
        if (i_item.power_on) begin
            o_state.off_delay_count = i_cfg.sensor_off_delay;
        end else if (i_state.off_delay_count != 16'd0) begin
            o_state.off_delay_count = i_state.off_delay_count - 16'd1;
            on_time_mid = pfist_pkg::ON_TIME_MAX;
        end

        sense = i_item.power_on || (o_state.off_delay_count != 16'd0)
                || (i_item.run_time < i_cfg.boot_sensor_window);

        if (sense) begin
            if (on_time_mid != pfist_pkg::ON_TIME_MAX && i_item.power_on) begin
                o_state.on_time_count = on_time_mid + 16'd1;
            end else begin
                o_state.on_time_count = on_time_mid;
            end
        end else begin
            o_state.on_time_count = 16'd0;
        end
    end

    always_comb begin
        unique case (lvl)
            pfist_pkg::LVL_SLEEP: rpm = i_cfg.rpm_sleep;
            pfist_pkg::LVL_LOW:   rpm = i_cfg.rpm_low;
            pfist_pkg::LVL_MID:   rpm = i_cfg.rpm_mid;
            pfist_pkg::LVL_HIGH:  rpm = i_cfg.rpm_high;
            default:              rpm = 16'd0;
        endcase
    end

    assign o_result.fan_level        = lvl;
    assign o_result.target_rpm       = rpm;
    assign o_result.ion_on           = i_item.power_on && i_item.ion_allowed
                                       && (i_item.work_mode != pfist_pkg::WORK_SLEEP)
                                       && !i_item.door_right_open
                                       && !i_item.door_left_open && !i_item.tilt_fault;
    assign o_result.sensor_supply_on = sense;
    assign o_result.sensor_on_time   = o_state.on_time_count;
    assign o_result.worst_quality    = o_state.last_quality;
    assign o_result.auto_fan_level   = o_state.last_auto_level;

endmodule

`default_nettype wire

// ===== sim/tb_purifier_fan_ion_sensor_tick_core.sv =====
// self-checking testbench for purifier_fan_ion_sensor_tick_core: directed and random ticks,
// a cycle-free predictor of every result field, random gaps on both streams
// depends on pfist_pkg and the core itself
module tb_purifier_fan_ion_sensor_tick_core;
    timeunit 1ns;
    timeprecision 1ps;

    // fault flags packed as {link, door right, door left, tilt, fan}
    localparam logic [4:0] FLT_NONE   = 5'b00000;
    localparam logic [4:0] FLT_FAN    = 5'b00001;
    localparam logic [4:0] FLT_TILT   = 5'b00010;
    localparam logic [4:0] FLT_DOOR_L = 5'b00100;
    localparam logic [4:0] FLT_DOOR_R = 5'b01000;
    localparam logic [4:0] FLT_LINK   = 5'b10000;
    localparam logic [4:0] FLT_ALL    = 5'b11111;

    localparam pfist_pkg::t_cfg CFG_DEFAULT =
        '{16'd300, 16'd500, 16'd650, 16'd800, 8'd30, 16'd600, 8'd60};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    pfist_pkg::t_cfg    unit_cfg = CFG_DEFAULT;
    pfist_pkg::t_state  unit_state = '0;
    pfist_pkg::t_result pending_results[$];
    int      mismatches = 0;
    bit      steady = 1'b0;
    bit      mains_on = 1'b1;

    purifier_fan_ion_sensor_tick_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 36);
    end

    // one tick of the controller: updates the tracked state, returns the result
    function automatic pfist_pkg::t_result predict_tick(input pfist_pkg::t_item it);
        pfist_pkg::t_result r;
        logic [1:0] worst;
        logic [2:0] lvl;
        logic       sensing;
        if (it.power_on && !it.fan_fault && !it.tilt_fault && !it.door_left_open
                && !it.door_right_open && !it.link_fault) begin
            if (unit_state.hold_count != 0) begin
                unit_state.hold_count = unit_state.hold_count - 8'd1;
                lvl = pfist_pkg::LVL_MID;
            end else if (it.work_mode == pfist_pkg::WORK_AUTO) begin
                worst = it.pm_level;
                if (it.voc_level > worst) worst = it.voc_level;
                if (it.formaldehyde_level > worst) worst = it.formaldehyde_level;
                unit_state.last_quality = worst;
                lvl = {1'b0, worst} + 3'd1;
                unit_state.last_auto_level = lvl;
            end else if (it.work_mode == pfist_pkg::WORK_LOW) begin
                lvl = pfist_pkg::LVL_LOW;
            end else if (it.work_mode == pfist_pkg::WORK_MID) begin
                lvl = pfist_pkg::LVL_MID;
            end else if (it.work_mode == pfist_pkg::WORK_HIGH) begin
                lvl = pfist_pkg::LVL_HIGH;
            end else begin
                // sleep and the unused codes above it
                lvl = pfist_pkg::LVL_SLEEP;
            end
        end else begin
            unit_state.hold_count = unit_cfg.startup_hold_ticks;
            lvl = pfist_pkg::LVL_OFF;
        end

        // ion only tests for the sleep code itself
        r.ion_on = it.power_on && it.ion_allowed && it.work_mode != pfist_pkg::WORK_SLEEP
            && !it.door_right_open && !it.door_left_open && !it.tilt_fault;

        if (it.power_on) begin
            unit_state.off_delay_count = unit_cfg.sensor_off_delay;
        end else if (unit_state.off_delay_count != 0) begin
            unit_state.off_delay_count = unit_state.off_delay_count - 16'd1;
            unit_state.on_time_count = pfist_pkg::ON_TIME_MAX;
        end
        sensing = it.power_on || unit_state.off_delay_count != 0
            || it.run_time < unit_cfg.boot_sensor_window;
        if (sensing) begin
            if (unit_state.on_time_count != pfist_pkg::ON_TIME_MAX && it.power_on)
                unit_state.on_time_count = unit_state.on_time_count + 16'd1;
        end else begin
            unit_state.on_time_count = '0;
        end

        case (lvl)
            pfist_pkg::LVL_SLEEP: r.target_rpm = unit_cfg.rpm_sleep;
            pfist_pkg::LVL_LOW:   r.target_rpm = unit_cfg.rpm_low;
            pfist_pkg::LVL_MID:   r.target_rpm = unit_cfg.rpm_mid;
            pfist_pkg::LVL_HIGH:  r.target_rpm = unit_cfg.rpm_high;
            default:              r.target_rpm = '0;
        endcase
        r.fan_level        = lvl;
        r.sensor_supply_on = sensing;
        r.sensor_on_time   = unit_state.on_time_count;
        r.worst_quality    = unit_state.last_quality;
        r.auto_fan_level   = unit_state.last_auto_level;
        return r;
    endfunction

    function automatic pfist_pkg::t_item tick_of(input bit pwr, input logic [4:0] flt,
            input logic [2:0] mode, input bit ion, input logic [1:0] pm,
            input logic [1:0] voc, input logic [1:0] ch2o, input logic [7:0] rt);
        pfist_pkg::t_item it;
        it.power_on           = pwr;
        it.fan_fault          = flt[0];
        it.tilt_fault         = flt[1];
        it.door_left_open     = flt[2];
        it.door_right_open    = flt[3];
        it.link_fault         = flt[4];
        it.work_mode          = mode;
        it.ion_allowed        = ion;
        it.pm_level           = pm;
        it.voc_level          = voc;
        it.formaldehyde_level = ch2o;
        it.run_time           = rt;
        return it;
    endfunction

    // mostly runs of ticks that follow a toggling mains power with rare faults; some fully random noise
    function automatic pfist_pkg::t_item rand_tick();
        logic [4:0] flt;
        logic [2:0] mode;
        logic [7:0] rt;
        bit         noisy;
        bit         pwr;
        noisy = $urandom_range(0, 99) < 15;
        if ($urandom_range(0, 99) < 7) mains_on = !mains_on;
        pwr = noisy ? 1'($urandom_range(0, 1)) : mains_on;
        for (int k = 0; k < 5; k++)
            flt[k] = $urandom_range(0, 99) < (noisy ? 50 : 3);
        mode = ($urandom_range(0, 99) < 40) ? pfist_pkg::WORK_AUTO : 3'($urandom_range(0, 7));
        if ($urandom_range(0, 1))
            rt = 8'($urandom);
        else
            rt = unit_cfg.boot_sensor_window + 8'($urandom_range(0, 2)) - 8'd1;
        return tick_of(pwr, flt, mode, $urandom_range(0, 99) < 80,
            2'($urandom), 2'($urandom), 2'($urandom), rt);
    endfunction

    task automatic report_error(input string msg);
        if (mismatches < 10) $display("%t %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic send_tick(input pfist_pkg::t_item it);
        while (!steady && $urandom_range(0, 99) < 36) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.run_time, it.formaldehyde_level, it.voc_level, it.pm_level,
            it.ion_allowed, it.work_mode, it.link_fault, it.door_right_open,
            it.door_left_open, it.tilt_fault, it.fan_fault, it.power_on};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(predict_tick(it));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            pfist_pkg::REG_RPM_SLEEP:    unit_cfg.rpm_sleep          = val;
            pfist_pkg::REG_RPM_LOW:      unit_cfg.rpm_low            = val;
            pfist_pkg::REG_RPM_MID:      unit_cfg.rpm_mid            = val;
            pfist_pkg::REG_RPM_HIGH:     unit_cfg.rpm_high           = val;
            pfist_pkg::REG_STARTUP_HOLD: unit_cfg.startup_hold_ticks = val[7:0];
            pfist_pkg::REG_SENSOR_DELAY: unit_cfg.sensor_off_delay   = val;
            pfist_pkg::REG_BOOT_WINDOW:  unit_cfg.boot_sensor_window = val[7:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // stop sending and let every pending result drain
    task automatic wait_idle();
        int guard = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0 && guard < 2000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic load_settings(input pfist_pkg::t_cfg c);
        wait_idle();
        write_reg(pfist_pkg::REG_RPM_SLEEP, c.rpm_sleep);
        write_reg(pfist_pkg::REG_RPM_LOW, c.rpm_low);
        write_reg(pfist_pkg::REG_RPM_MID, c.rpm_mid);
        write_reg(pfist_pkg::REG_RPM_HIGH, c.rpm_high);
        write_reg(pfist_pkg::REG_STARTUP_HOLD, {8'd0, c.startup_hold_ticks});
        write_reg(pfist_pkg::REG_SENSOR_DELAY, c.sensor_off_delay);
        write_reg(pfist_pkg::REG_BOOT_WINDOW, {8'd0, c.boot_sensor_window});
    endtask

    task automatic run_phase(input pfist_pkg::t_cfg c, input int n, input bit no_gaps);
        load_settings(c);
        steady = no_gaps;
        repeat (n) send_tick(rand_tick());
        steady = 1'b0;
    endtask

    function automatic pfist_pkg::t_cfg rand_cfg();
        return '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
            8'($urandom_range(0, 6)), 16'($urandom_range(0, 12)), 8'($urandom)};
    endfunction

    // no hold right after reset, so every mode shows at once
    task automatic test_fan_modes();
        send_tick(tick_of(1, FLT_NONE, pfist_pkg::WORK_AUTO, 1, 2'd3, 2'd0, 2'd0, 8'd0));
        send_tick(tick_of(1, FLT_NONE, pfist_pkg::WORK_AUTO, 1, 2'd0, 2'd2, 2'd1, 8'd0));
        send_tick(tick_of(1, FLT_NONE, pfist_pkg::WORK_AUTO, 1, 2'd0, 2'd0, 2'd3, 8'd100));
        send_tick(tick_of(1, FLT_NONE, pfist_pkg::WORK_AUTO, 1, 2'd0, 2'd0, 2'd0, 8'd255));
        send_tick(tick_of(1, FLT_NONE, pfist_pkg::WORK_LOW, 1, 2'd3, 2'd3, 2'd3, 8'd10));
        send_tick(tick_of(1, FLT_NONE, pfist_pkg::WORK_MID, 1, 2'd1, 2'd1, 2'd1, 8'd59));
        send_tick(tick_of(1, FLT_NONE, pfist_pkg::WORK_HIGH, 0, 2'd2, 2'd1, 2'd0, 8'd60));
        send_tick(tick_of(1, FLT_NONE, pfist_pkg::WORK_SLEEP, 1, 2'd3, 2'd0, 2'd1, 8'd61));
        // unused mode codes run the fan at sleep but, unlike sleep, do not block the ion
        send_tick(tick_of(1, FLT_NONE, pfist_pkg::WORK_SLEEP + 3'd1, 1,
            2'd0, 2'd1, 2'd2, 8'd0));
        send_tick(tick_of(1, FLT_NONE, pfist_pkg::WORK_SLEEP + 3'd2, 0,
            2'd1, 2'd2, 2'd3, 8'd128));
        send_tick(tick_of(1, FLT_NONE, pfist_pkg::WORK_SLEEP + 3'd3, 1,
            2'd3, 2'd3, 2'd3, 8'd255));
    endtask

    task automatic test_fault_inputs();
        send_tick(tick_of(1, FLT_FAN, pfist_pkg::WORK_HIGH, 1, 2'd0, 2'd0, 2'd0, 8'd0));
        send_tick(tick_of(1, FLT_TILT, pfist_pkg::WORK_HIGH, 1, 2'd0, 2'd0, 2'd0, 8'd0));
        send_tick(tick_of(1, FLT_DOOR_L, pfist_pkg::WORK_AUTO, 1, 2'd0, 2'd0, 2'd0, 8'd0));
        send_tick(tick_of(1, FLT_DOOR_R, pfist_pkg::WORK_AUTO, 1, 2'd0, 2'd0, 2'd0, 8'd0));
        send_tick(tick_of(1, FLT_LINK, pfist_pkg::WORK_LOW, 1, 2'd3, 2'd3, 2'd3, 8'd0));
        // off with the sensor still held by the off delay
        send_tick(tick_of(0, FLT_ALL, pfist_pkg::WORK_AUTO, 1, 2'd3, 2'd3, 2'd3, 8'd255));
        send_tick(tick_of(1, FLT_NONE, pfist_pkg::WORK_AUTO, 1, 2'd3, 2'd3, 2'd3, 8'd255));
    endtask

    // short hold and delay, zero boot window: the supply drops after power-off
    task automatic test_startup_hold();
        load_settings('{16'd300, 16'd500, 16'd650, 16'd800, 8'd2, 16'd2, 8'd0});
        send_tick(tick_of(0, FLT_NONE, pfist_pkg::WORK_HIGH, 1, 2'd0, 2'd0, 2'd0, 8'd0));
        send_tick(tick_of(1, FLT_NONE, pfist_pkg::WORK_HIGH, 1, 2'd0, 2'd0, 2'd0, 8'd0));
        send_tick(tick_of(1, FLT_NONE, pfist_pkg::WORK_HIGH, 1, 2'd0, 2'd0, 2'd0, 8'd0));
        send_tick(tick_of(1, FLT_NONE, pfist_pkg::WORK_AUTO, 1, 2'd1, 2'd0, 2'd0, 8'd0));
        send_tick(tick_of(0, FLT_NONE, pfist_pkg::WORK_AUTO, 1, 2'd0, 2'd0, 2'd0, 8'd0));
        send_tick(tick_of(0, FLT_NONE, pfist_pkg::WORK_AUTO, 1, 2'd0, 2'd0, 2'd0, 8'd0));
        send_tick(tick_of(0, FLT_NONE, pfist_pkg::WORK_AUTO, 1, 2'd0, 2'd0, 2'd0, 8'd255));
    endtask

    task automatic test_register_extremes();
        run_phase('{16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0, 8'd0}, 120, 1'b0);
        run_phase('{16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff, 16'hffff, 8'hff},
            120, 1'b0);
    endtask

    task automatic test_random_traffic();
        run_phase(rand_cfg(), 250, 1'b0);
        run_phase(rand_cfg(), 180, 1'b1);
        run_phase(rand_cfg(), 180, 1'b0);
    endtask

    always @(posedge i_clk) begin : check_results
        pfist_pkg::t_result got;
        pfist_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.fan_level        = m_axis_tdata[2:0];
            got.target_rpm       = m_axis_tdata[18:3];
            got.ion_on           = m_axis_tdata[19];
            got.sensor_supply_on = m_axis_tdata[20];
            got.sensor_on_time   = m_axis_tdata[36:21];
            got.worst_quality    = m_axis_tdata[38:37];
            got.auto_fan_level   = m_axis_tdata[41:39];
            if (pending_results.size() == 0) begin
                report_error($sformatf("result transfer with none pending: %h", m_axis_tdata));
            end else begin
                want = pending_results.pop_front();
                if (got !== want || m_axis_tdata[47:42] !== '0)
                    report_error($sformatf({"tick mismatch: want lvl %0d rpm %0d ion %b sup %b ",
                        "on %0d wq %0d afl %0d, got lvl %0d rpm %0d ion %b sup %b on %0d ",
                        "wq %0d afl %0d pad %h"},
                        want.fan_level, want.target_rpm, want.ion_on, want.sensor_supply_on,
                        want.sensor_on_time, want.worst_quality, want.auto_fan_level,
                        got.fan_level, got.target_rpm, got.ion_on, got.sensor_supply_on,
                        got.sensor_on_time, got.worst_quality, got.auto_fan_level,
                        m_axis_tdata[47:42]));
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fan_modes();
        test_fault_inputs();
        test_startup_hold();
        test_register_extremes();
        test_random_traffic();
        wait_idle();
        if (pending_results.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_results.size()));
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
